// File: rtl/dwarf_cfa_instruction_emitter_core_macros.svh
// ----------------------------------------------------------------------------
// dwarf_cfa_instruction_emitter_core_macros
// assertion macros shared by the checker of the cfa instruction emitter
// ----------------------------------------------------------------------------
`ifndef DWARF_CFA_INSTRUCTION_EMITTER_CORE_MACROS_SVH
`define DWARF_CFA_INSTRUCTION_EMITTER_CORE_MACROS_SVH

// same-cycle implication
`define DCFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DCFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dcfa_pkg.sv
// ----------------------------------------------------------------------------
// dcfa_pkg
// types and constants of the dwarf cfa instruction emitter
// ----------------------------------------------------------------------------
`default_nettype none

package dcfa_pkg;

   localparam int MaxBytes = 16;
   localparam int ByteBits = MaxBytes * 8;
   localparam int CountW   = $clog2(MaxBytes + 1);

   localparam logic [1:0] OpProlog   = 2'd0;
   localparam logic [1:0] OpEpilog   = 2'd1;
   localparam logic [1:0] OpPreserve = 2'd2;
   localparam logic [1:0] OpStart    = 2'd3;

   localparam logic [1:0] StOk        = 2'd0;
   localparam logic [1:0] StBackward  = 2'd1;
   localparam logic [1:0] StTooSmall  = 2'd2;
   localparam logic [1:0] StBadOffset = 2'd3;

   localparam logic [7:0] DwAdvShort       = 8'h40;
   localparam logic [7:0] DwAdv1           = 8'h02;
   localparam logic [7:0] DwAdv2           = 8'h03;
   localparam logic [7:0] DwAdv4           = 8'h04;
   localparam logic [7:0] DwDefCfaOffset   = 8'h0e;
   localparam logic [7:0] DwDefCfaRegister = 8'h0d;
   localparam logic [7:0] DwDefCfa         = 8'h0c;
   localparam logic [7:0] DwOffset         = 8'h80;
   localparam logic [7:0] RegRbp           = 8'd6;
   localparam logic [7:0] RegRsp           = 8'd7;
   localparam logic [7:0] CfaOffset16      = 8'd16;
   localparam logic [7:0] RbpSlot          = 8'd2;
   localparam logic [7:0] RspOffset        = 8'd8;
   localparam logic [7:0] ErrByte          = 8'h00;

   localparam logic [31:0] PrologLead   = 32'd3;
   localparam logic [31:0] EpilogLead   = 32'd1;
   localparam logic [31:0] PrologMinPos = 32'd4;
   localparam logic [31:0] EpilogMinPos = 32'd2;
   localparam logic [31:0] AdvShortMax  = 32'h3F;
   localparam logic [31:0] Adv1Max      = 32'hFF;
   localparam logic [31:0] Adv2Max      = 32'hFFFF;

   localparam logic signed [31:0] MaxSaveOffset = -32'sd8;
   localparam logic [32:0]        SaveBias      = 33'd16;

   localparam logic [7:0] AdvPrologTail = DwAdvShort + PrologLead[7:0];
   localparam logic [7:0] OffsetRbp     = DwOffset | RegRbp;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] code_pos;
      logic [3:0]  dwarf_reg;
      logic [31:0] frame_offset;
      logic [31:0] last_pos;
      logic [1:0]  status;
   } event_type;

   typedef struct packed {
      logic [ByteBits-1:0] bytes;
      logic [CountW-1:0]   count;
      logic [1:0]          status;
   } burst_type;

endpackage

`default_nettype wire

// File: rtl/dcfa_front.sv
// ----------------------------------------------------------------------------
// dcfa_front
// input register, event checks and last code position tracking
// ----------------------------------------------------------------------------
`default_nettype none

module dcfa_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_tuser,   // opcode
   input  wire logic [71:0]           req_tdata,   // code_pos, dwarf_reg, frame_offset, pad
   input  wire logic                  sink_ready,
   output logic                       ev_valid,
   output dcfa_pkg::event_type        ev
);

   logic                last_valid_unused;
   logic                ev_valid_ff, ev_valid_in;
   dcfa_pkg::event_type ev_ff, ev_in;
   logic [31:0]         last_pos_ff, last_pos_in;
   logic                accept, take;
   logic [31:0]         pos, offs, new_pos;
   logic [1:0]          st;

   assign pos    = req_tdata[31:0];
   assign offs   = req_tdata[67:36];
   assign take   = ev_valid_ff && sink_ready;
   assign req_tready = !ev_valid_ff || sink_ready;
   assign accept = req_tvalid && req_tready;
   assign last_valid_unused = 1'b0;

   always_comb begin
      st      = dcfa_pkg::StOk;
      new_pos = pos;
      unique case (req_tuser)
         dcfa_pkg::OpProlog: begin
            if (pos < dcfa_pkg::PrologMinPos) begin
               st = dcfa_pkg::StTooSmall;
            end else if (pos - dcfa_pkg::PrologLead < last_pos_ff) begin
               st = dcfa_pkg::StBackward;
            end
         end
         dcfa_pkg::OpEpilog: begin
            new_pos = pos - dcfa_pkg::EpilogLead;
            if (pos < dcfa_pkg::EpilogMinPos) begin
               st = dcfa_pkg::StTooSmall;
            end else if (pos - dcfa_pkg::EpilogLead < last_pos_ff) begin
               st = dcfa_pkg::StBackward;
            end
         end
         dcfa_pkg::OpPreserve: begin
            if (pos < last_pos_ff) begin
               st = dcfa_pkg::StBackward;
            end else if ($signed(offs) > dcfa_pkg::MaxSaveOffset) begin
               st = dcfa_pkg::StBadOffset;
            end
         end
         dcfa_pkg::OpStart: begin
            new_pos = '0;
         end
      endcase
   end

   always_comb begin
      last_pos_in = last_pos_ff;
      ev_valid_in = ev_valid_ff;
      ev_in       = ev_ff;
      if (accept) begin
         if (st == dcfa_pkg::StOk) begin
            last_pos_in = new_pos;
         end
         ev_valid_in        = (req_tuser != dcfa_pkg::OpStart);
         ev_in.opcode       = req_tuser;
         ev_in.code_pos     = pos;
         ev_in.dwarf_reg    = req_tdata[35:32];
         ev_in.frame_offset = offs;
         ev_in.last_pos     = last_pos_ff;
         ev_in.status       = st;
      end else if (take) begin
         ev_valid_in = last_valid_unused;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
         last_pos_ff <= '0;
      end else begin
         ev_valid_ff <= ev_valid_in;
         last_pos_ff <= last_pos_in;
      end
      ev_ff <= ev_in;
   end

   assign ev_valid = ev_valid_ff;
   assign ev       = ev_ff;

endmodule

`default_nettype wire

// File: rtl/dcfa_encode.sv
// ----------------------------------------------------------------------------
// dcfa_encode
// builds the instruction byte burst of one registered event
// ----------------------------------------------------------------------------
`default_nettype none

module dcfa_encode (
   input  wire dcfa_pkg::event_type ev,
   output dcfa_pkg::burst_type      burst
);

   logic [31:0]                   target, delta;
   logic                          has_adv;
   logic [2:0]                    adv_len;
   logic [39:0]                   adv_bytes;
   logic [32:0]                   scaled;
   logic [28:0]                   uv;
   logic [34:0]                   uvx;
   logic [2:0]                    uleb_len;
   logic [39:0]                   uleb_bytes;
   logic [55:0]                   tail;
   logic [3:0]                    tail_len;
   logic [dcfa_pkg::ByteBits-1:0] wide;

   always_comb begin
      unique case (ev.opcode)
         dcfa_pkg::OpProlog:   target = ev.code_pos - dcfa_pkg::PrologLead;
         dcfa_pkg::OpEpilog:   target = ev.code_pos - dcfa_pkg::EpilogLead;
         dcfa_pkg::OpPreserve: target = ev.code_pos;
         dcfa_pkg::OpStart:    target = ev.code_pos;
      endcase
   end

   assign delta   = target - ev.last_pos;
   assign has_adv = target > ev.last_pos;

   // location advance in its shortest form
   always_comb begin
      priority if (!has_adv) begin
         adv_len   = 3'd0;
         adv_bytes = '0;
      end else if (delta <= dcfa_pkg::AdvShortMax) begin
         adv_len   = 3'd1;
         adv_bytes = {32'b0, dcfa_pkg::DwAdvShort + delta[7:0]};
      end else if (delta <= dcfa_pkg::Adv1Max) begin
         adv_len   = 3'd2;
         adv_bytes = {24'b0, delta[7:0], dcfa_pkg::DwAdv1};
      end else if (delta <= dcfa_pkg::Adv2Max) begin
         adv_len   = 3'd3;
         adv_bytes = {16'b0, delta[15:0], dcfa_pkg::DwAdv2};
      end else begin
         adv_len   = 3'd5;
         adv_bytes = {delta, dcfa_pkg::DwAdv4};
      end
   end

   // factored save offset as uleb128
   assign scaled = dcfa_pkg::SaveBias - {ev.frame_offset[31], ev.frame_offset};
   assign uv     = scaled[31:3];
   assign uvx    = {6'b0, uv};

   always_comb begin
      priority if (uv[28]) begin
         uleb_len = 3'd5;
      end else if (uv[27:21] != 7'd0) begin
         uleb_len = 3'd4;
      end else if (uv[20:14] != 7'd0) begin
         uleb_len = 3'd3;
      end else if (uv[13:7] != 7'd0) begin
         uleb_len = 3'd2;
      end else begin
         uleb_len = 3'd1;
      end
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         uleb_bytes[8*i +: 8] = {(3'(i + 1) < uleb_len), uvx[7*i +: 7]};
      end
   end

   always_comb begin
      unique case (ev.opcode)
         dcfa_pkg::OpProlog: begin
            tail = {dcfa_pkg::RegRbp, dcfa_pkg::DwDefCfaRegister, dcfa_pkg::AdvPrologTail,
                    dcfa_pkg::RbpSlot, dcfa_pkg::OffsetRbp, dcfa_pkg::CfaOffset16,
                    dcfa_pkg::DwDefCfaOffset};
            tail_len = 4'd7;
         end
         dcfa_pkg::OpEpilog: begin
            tail     = {32'b0, dcfa_pkg::RspOffset, dcfa_pkg::RegRsp, dcfa_pkg::DwDefCfa};
            tail_len = 4'd3;
         end
         dcfa_pkg::OpPreserve: begin
            tail     = {8'b0, uleb_bytes, dcfa_pkg::DwOffset | {4'b0, ev.dwarf_reg}};
            tail_len = {1'b0, uleb_len} + 4'd1;
         end
         dcfa_pkg::OpStart: begin
            tail     = '0;
            tail_len = 4'd0;
         end
      endcase
   end

   assign wide = (dcfa_pkg::ByteBits'(tail) << {adv_len, 3'b000})
               | dcfa_pkg::ByteBits'(adv_bytes);

   always_comb begin
      burst.status = ev.status;
      if (ev.status != dcfa_pkg::StOk) begin
         burst.bytes = dcfa_pkg::ByteBits'(dcfa_pkg::ErrByte);
         burst.count = dcfa_pkg::CountW'(1);
      end else begin
         burst.bytes = wide;
         burst.count = dcfa_pkg::CountW'(adv_len) + dcfa_pkg::CountW'(tail_len);
      end
   end

endmodule

`default_nettype wire

// File: rtl/dcfa_serial.sv
// ----------------------------------------------------------------------------
// dcfa_serial
// result register that hands out a burst one byte per word
// ----------------------------------------------------------------------------
`default_nettype none

module dcfa_serial (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load_valid,
   input  wire dcfa_pkg::burst_type burst,
   output logic                     load_ok,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,   // out_byte
   output logic                     rsp_tlast,
   output logic [1:0]               rsp_tuser    // status
);

   logic                          valid_ff, valid_in;
   logic [dcfa_pkg::CountW-1:0]   left_ff, left_in;
   logic [dcfa_pkg::ByteBits-1:0] buf_ff, buf_in;
   logic [1:0]                    status_ff, status_in;
   logic                          final_word;

   assign final_word = (left_ff == dcfa_pkg::CountW'(1));
   assign load_ok    = !valid_ff || (rsp_tready && final_word);

   always_comb begin
      valid_in  = valid_ff;
      left_in   = left_ff;
      buf_in    = buf_ff;
      status_in = status_ff;
      if (load_ok && load_valid) begin
         valid_in  = 1'b1;
         left_in   = burst.count;
         buf_in    = burst.bytes;
         status_in = burst.status;
      end else if (valid_ff && rsp_tready) begin
         valid_in = !final_word;
         left_in  = left_ff - dcfa_pkg::CountW'(1);
         buf_in   = buf_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
      end
      buf_ff    <= buf_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = buf_ff[7:0];
   assign rsp_tlast  = final_word;
   assign rsp_tuser  = status_ff;

endmodule

`default_nettype wire

// File: rtl/dwarf_cfa_instruction_emitter_core.sv
// ----------------------------------------------------------------------------
// dwarf_cfa_instruction_emitter_core
// turns x64 frame events into dwarf call frame instruction bytes
// ----------------------------------------------------------------------------
// Events enter an input register at up to one per cycle while req_tready is
// high; the byte burst of the registered event (a location advance in its
// shortest form, then the cfa rules) is built and loaded into the result
// register when load_ok allows; that register sends it one byte per word,
// tlast on the final byte and the status in tuser. An event emits 1 byte
// for an error, 3 to 8 for an epilog, 7 to 12 for a prolog, 2 to 11 for a
// preserve; a start event emits nothing. The result register, at one byte
// per cycle while rsp_tready is high, sets the sustained rate. The last code
// position is updated as each event with ok status is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module dwarf_cfa_instruction_emitter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // opcode
   input  wire logic [71:0] req_tdata,   // code_pos, dwarf_reg, frame_offset, pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser    // status
);

   logic                ev_valid, load_ok;
   dcfa_pkg::event_type ev;
   dcfa_pkg::burst_type burst;

   dcfa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .sink_ready (load_ok),
      .ev_valid   (ev_valid),
      .ev         (ev)
   );

   dcfa_encode u_encode (
      .ev    (ev),
      .burst (burst)
   );

   dcfa_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load_valid (ev_valid),
      .burst      (burst),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/dcfa_checker.sv
// ----------------------------------------------------------------------------
// dcfa_checker
// port-level checks on the result channel of the cfa instruction emitter
// ----------------------------------------------------------------------------
`default_nettype none

`include "dwarf_cfa_instruction_emitter_core_macros.svh"

module dcfa_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic [1:0] rsp_tuser
);

   // an error is a single zero byte
   `DCFA_ASSERT_NOW(a_err_single, clock, reset, rsp_tvalid && (rsp_tuser != dcfa_pkg::StOk), rsp_tlast && (rsp_tdata == dcfa_pkg::ErrByte), "error word not a lone zero byte")

   // a burst continues without a gap and stays ok
   `DCFA_ASSERT_NEXT(a_burst_cont, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tuser == dcfa_pkg::StOk), "burst broken or status changed")

   // stalled word holds
   `DCFA_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled word changed")

   // nothing pending right after reset
   `DCFA_ASSERT_NOW(a_reset_idle, clock, reset, $fell(reset), !rsp_tvalid, "word valid after reset")

endmodule

bind dwarf_cfa_instruction_emitter_core dcfa_checker u_dcfa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
